// File: sv/sha256_pkg.sv
`timescale 1ns / 1ps
// Package for the SHA-256 stream hasher: constants, the round table and the
// shared functions. Depends on nothing.
package sha256_pkg;

	localparam int DataW = 8;
	localparam int WordW = 32;
	localparam int IdxW = 3;
	localparam int InTdataW = 8;
	localparam int InTuserW = 2;
	localparam int OutTdataW = 32;
	localparam int OutTuserW = 4;
	localparam int FifoDepth = 4;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} item_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t ror(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

// File: sv/sha256_front.sv
`timescale 1ns / 1ps
// Front end of the hasher: a small queue of accepted input words.
// Depends on sha256_pkg.
module sha256_front #(
	parameter int Depth = sha256_pkg::FifoDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha256_pkg::item_t   in_item,
	output logic                q_valid,
	input  logic                q_ready,
	output sha256_pkg::item_t   q_item
);
	import sha256_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	item_t            mem_q [Depth];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             push, pop;

	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: sv/sha256_back.sv
`timescale 1ns / 1ps
// Back end of the hasher: byte packing, padding, the round-per-cycle
// compression engine and the digest output register. Depends on sha256_pkg.
module sha256_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  sha256_pkg::item_t           q_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 out_word,
	output logic [2:0]                  out_index,
	output logic                        out_last
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BYTE, ST_PAD, ST_COMP, ST_EMIT
	} state_t;

	state_t       state_q;
	word_t        w_q [16];
	word_t        h_q [8];
	word_t        v_q [8];
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic [63:0]  plen_q;
	logic [6:0]   round_q;
	logic         eom_q;
	logic         pad_q;
	logic [2:0]   emit_q;
	logic [7:0]   byte_q;
	logic [7:0]   len_byte;
	logic [7:0]   pad_byte;
	logic [7:0]   cur_byte;
	logic         do_byte;
	word_t        t1, t2, wt, wnew, packed_w;
	logic [3:0]   widx;
	logic [4:0]   sh;
	logic         pad_last_done;
	logic         lenw_q;

	always_comb begin
		case (fill_q[2:0])
			3'd0: len_byte = plen_q[63:56];
			3'd1: len_byte = plen_q[55:48];
			3'd2: len_byte = plen_q[47:40];
			3'd3: len_byte = plen_q[39:32];
			3'd4: len_byte = plen_q[31:24];
			3'd5: len_byte = plen_q[23:16];
			3'd6: len_byte = plen_q[15:8];
			default: len_byte = plen_q[7:0];
		endcase
	end

	assign pad_byte = !pad_q ? PadByte
		: (lenw_q && fill_q[5:3] == 3'd7) ? len_byte : 8'h00;

	assign cur_byte = (state_q == ST_PAD) ? pad_byte : byte_q;
	assign widx     = fill_q[5:2];
	assign sh       = {~fill_q[1:0], 3'b000};
	assign packed_w = (fill_q[1:0] == 2'd0) ? (word_t'(cur_byte) << sh)
		: (w_q[widx] | (word_t'(cur_byte) << sh));

	assign wt   = w_q[0];
	assign wnew = (ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
		+ (ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
	assign t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(round_q[5:0]) + wt;
	assign t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign q_ready   = (state_q == ST_IDLE);
	assign do_byte   = (state_q == ST_BYTE) || (state_q == ST_PAD);
	assign out_valid = (state_q == ST_EMIT);
	assign out_word  = h_q[emit_q];
	assign out_index = emit_q;
	assign out_last  = (emit_q == 3'd7);

	always_ff @(posedge clk) begin
		if (do_byte) begin
			w_q[widx] <= packed_w;
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wnew;
		end
		if (do_byte && fill_q == 6'd63) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == ST_COMP && round_q != 7'd64) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			len_q   <= '0;
			plen_q  <= '0;
			round_q <= '0;
			eom_q   <= 1'b0;
			pad_q   <= 1'b0;
			emit_q  <= '0;
			byte_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_h(3'(i));
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						eom_q  <= q_item.eom;
						pad_q  <= 1'b0;
						byte_q <= q_item.data;
						if (q_item.present) begin
							len_q  <= len_q + 64'd8;
							plen_q <= len_q + 64'd8;
							state_q <= ST_BYTE;
						end else if (q_item.eom) begin
							plen_q  <= len_q;
							state_q <= ST_PAD;
						end
					end
				end
				ST_BYTE, ST_PAD: begin
					if (state_q == ST_PAD) begin
						pad_q <= 1'b1;
					end
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						round_q <= '0;
						state_q <= ST_COMP;
					end else if (state_q == ST_PAD) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= eom_q ? ST_PAD : ST_IDLE;
					end
				end
				ST_COMP: begin
					if (round_q == 7'd64) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= h_q[i] + v_q[i];
						end
						if (!eom_q) begin
							state_q <= ST_IDLE;
						end else if (pad_q && fill_q == 6'd0 && pad_last_done) begin
							emit_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_PAD;
						end
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= init_h(3'(i));
							end
							len_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lenw_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			lenw_q <= 1'b0;
		end else if (state_q == ST_PAD && fill_q == 6'd55) begin
			lenw_q <= 1'b1;
		end else if (state_q == ST_BYTE && fill_q == 6'd63) begin
			lenw_q <= 1'b0;
		end
	end

	assign pad_last_done = lenw_q;

endmodule

// File: sv/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// Top level of the SHA-256 stream hasher: input queue and hashing engine.
// Depends on sha256_pkg, sha256_front and sha256_back.
//
// Channel | Direction | Payload
// s_axis  | in        | tdata = data_byte, tuser = {end_of_message, byte_present}
// m_axis  | out       | tdata = digest_word, tuser = {last_word, word_index}
//
// A byte is packed in the idle and byte states; each full block then runs its rounds
// in the single round-per-cycle engine, which takes no new byte until it is done.
// An end word adds padding and one or two compressions,
// then eight digest words. Reset clears all control state and loads the initial hash.
// The four-word input queue keeps accepting while the engine or the output stalls, until it is full.
module sha256_stream_hasher_unit #(
	parameter int FifoDepth = sha256_pkg::FifoDepth
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [sha256_pkg::InTdataW-1:0]     s_axis_tdata,  // data_byte
	input  logic [sha256_pkg::InTuserW-1:0]     s_axis_tuser,  // byte_present, end_of_message
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [sha256_pkg::OutTdataW-1:0]    m_axis_tdata,  // digest_word
	output logic [sha256_pkg::OutTuserW-1:0]    m_axis_tuser   // word_index, last_word
);
	import sha256_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_ready;
	logic [2:0] idx;
	logic  last;

	assign in_item.data    = s_axis_tdata;
	assign in_item.present = s_axis_tuser[0];
	assign in_item.eom     = s_axis_tuser[1];

	sha256_front #(.Depth(FifoDepth)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	sha256_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(m_axis_tdata), .out_index(idx), .out_last(last)
	);

	assign m_axis_tuser = {last, idx};

endmodule

// File: verif/sha256_stream_hasher_unit_chk.sv
`timescale 1ns / 1ps
// Checker for the SHA-256 stream hasher: watches both stream channels, predicts
// each digest word with its own SHA-256 model and compares. Depends on sha256_pkg.
module sha256_stream_hasher_unit_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [3:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending_words
);
	import sha256_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	word_t       hash_st [8];
	logic [7:0]  msg_bytes [64];
	logic [5:0]  fill;
	logic [63:0] bit_len;
	digest_t     digest_q [$];

	function automatic word_t rotr(word_t v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress();
		word_t w [64];
		word_t v [8];
		word_t t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_bytes[4*t], msg_bytes[4*t+1], msg_bytes[4*t+2], msg_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (int i = 0; i < 8; i++)
			v[i] = hash_st[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_st[i] += v[i];
	endtask

	task automatic absorb_byte(logic [7:0] b);
		msg_bytes[fill] = b;
		fill++;
		if (fill == 0)
			compress();
	endtask

	task automatic hash_word_in(logic [7:0] b, logic present, logic eom);
		logic [63:0] len;
		digest_t d;
		if (present) begin
			absorb_byte(b);
			bit_len += 64'd8;
		end
		if (eom) begin
			len = bit_len;
			absorb_byte(PadByte);
			while (fill != 6'd56)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.word = hash_st[i];
				d.idx = i[2:0];
				d.last = (i == 7);
				digest_q.push_back(d);
			end
			for (int i = 0; i < 8; i++)
				hash_st[i] = init_h(i[2:0]);
			fill = '0;
			bit_len = '0;
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			hash_st[i] = init_h(i[2:0]);
		fill = '0;
		bit_len = '0;
		fail_count = 0;
		pending_words = 0;
	end

	always @(posedge clk) begin
		digest_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				hash_word_in(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digest word %h tuser %h", m_axis_tdata,
							m_axis_tuser);
				end else begin
					want = digest_q.pop_front();
					if (m_axis_tdata !== want.word || m_axis_tuser !== {want.last, want.idx})
						begin
						fail_count++;
						if (fail_count <= 10)
							$display("digest mismatch: expected %h idx %0d last %b, got %h tuser %h",
								want.word, want.idx, want.last, m_axis_tdata, m_axis_tuser);
					end
				end
			end
			pending_words <= digest_q.size();
		end
	end
endmodule

// File: verif/sha256_stream_hasher_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-256 stream hasher: drives byte streams with bursty
// gaps and output stalls, and gives the verdict. Depends on sha256_pkg, the hasher and the checker.
module sha256_stream_hasher_unit_tb;
	import sha256_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // data_byte
	logic [1:0]  s_axis_tuser;   // byte_present, end_of_message
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // digest_word
	logic [3:0]  m_axis_tuser;   // word_index, last_word
	int          fail_count;
	int          pending_words;
	int          idle_cycles;
	logic        hold_off;
	logic        stim_done;

	sha256_stream_hasher_unit dut (.*);

	sha256_stream_hasher_unit_chk checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_word(logic [7:0] b, logic present, logic eom);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= {eom, present};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic maybe_gap();
		if ($urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic send_msg(int len, int mode);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
			if ($urandom_range(0, 9) == 0)
				send_word(8'($urandom), 1'b0, 1'b0);
			send_word(b, 1'b1, (i == len - 1) && (mode != 3));
			maybe_gap();
		end
		if (len == 0 || mode == 3)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int lens [$];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		stim_done = 1'b0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_msg(0, 0);
		send_msg(1, 1);
		send_msg(1, 2);
		send_msg(3, 0);
		send_msg(2, 3);
		send_msg(2, 0);
		send_msg(1, 0);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'hff, 1'b0, 1'b0);
		lens = '{55, 56, 63, 64, 0, 5, 1, 9, 2, 0, 13, 3, 7, 4, 57, 11, 1};
		foreach (lens[i])
			send_msg(lens[i], $urandom_range(0, 3) == 0 ? 3 : 0);
		s_axis_tvalid <= 1'b0;
		stim_done <= 1'b1;
	end

	initial begin
		m_axis_tready = 1'b0;
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (300) begin
			@(posedge clk);
			m_axis_tready <= 1'b1;
		end
		hold_off <= 1'b1;
		m_axis_tready <= 1'b0;
		repeat (3000)
			@(posedge clk);
		hold_off <= 1'b0;
		forever begin
			@(posedge clk);
			m_axis_tready <= ($urandom_range(0, 99) < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		fork
			begin
				wait (stim_done === 1'b1);
				@(posedge clk);
				while (pending_words != 0)
					@(posedge clk);
				repeat (400)
					@(posedge clk);
			end
			begin
				wait (idle_cycles >= 20000);
				$display("TB_ERROR");
				$finish;
			end
		join_any
		if (fail_count == 0 && pending_words == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: filelist.f
sv/sha256_pkg.sv
sv/sha256_front.sv
sv/sha256_back.sv
sv/sha256_stream_hasher_unit.sv
verif/sha256_stream_hasher_unit_chk.sv
verif/sha256_stream_hasher_unit_tb.sv
